### rtl/swcr_pkg.sv
`timescale 1ns / 1ps

package swcr_pkg;

    localparam int COL_W     = 6;
    localparam int SAMPLE_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int NUM_W     = 20;
    localparam int QUO_W     = 4;
    localparam int DIV_ST    = 4;
    localparam int CFG_IDX_W = 4;
    localparam int OUT_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INPUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INPUT = CFG_IDX_W'(1);

    localparam logic [SAMPLE_W-1:0] MIN_INPUT_RST = 16'sd0;
    localparam logic [SAMPLE_W-1:0] MAX_INPUT_RST = 16'sd4095;

    localparam logic [QUO_W-1:0] HALF_STEPS = 4'd7;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } swcr_state_t;

    typedef struct packed {
        logic                wr_en;
        logic [COL_W-1:0]    wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [COL_W-1:0]    rd_addr;
        logic [COL_W-1:0]    col;
        logic                last;
    } swcr_cmd_t;

    typedef struct packed {
        logic advance;
    } swcr_status_t;

    function automatic logic [BYTE_W-1:0] pixel_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = 8'h40;
            3'd1:    b = 8'h10;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h04;
            3'd4:    b = 8'h02;
            3'd5:    b = 8'h01;
            3'd6:    b = 8'h01;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

### rtl/swcr_ctrl.sv
`timescale 1ns / 1ps

module swcr_ctrl
    import swcr_pkg::*;
#(
    parameter int COLUMNS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,
    output swcr_cmd_t           cmd,
    input  swcr_status_t        status
);

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [AW-1:0]    TOP_SLOT = AW'(COLUMNS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    swcr_state_t      state_reg, state_next;
    logic [AW-1:0]    newest_reg, newest_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [AW-1:0]    newest_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            newest_reg <= '0;
            rd_ptr_reg <= '0;
            col_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            rd_ptr_reg <= rd_ptr_next;
            col_reg    <= col_next;
        end
    end

    assign newest_dec = (newest_reg == '0) ? TOP_SLOT : newest_reg - AW'(1);

    always_comb
    begin
        state_next  = state_reg;
        newest_next = newest_reg;
        rd_ptr_next = rd_ptr_reg;
        col_next    = col_reg;
        s_tready    = 1'b0;
        cmd.wr_en   = 1'b0;
        cmd.wr_addr = COL_W'(newest_dec);
        cmd.wr_data = s_tdata;
        cmd.rd_en   = 1'b0;
        cmd.rd_addr = COL_W'(rd_ptr_reg);
        cmd.col     = col_reg;
        cmd.last    = (col_reg == LAST_COL);
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.wr_en   = 1'b1;
                    newest_next = newest_dec;
                    rd_ptr_next = newest_dec;
                    col_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.advance)
                begin
                    cmd.rd_en   = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == TOP_SLOT) ? '0 : rd_ptr_reg + AW'(1);
                    col_next    = col_reg + COL_W'(1);
                    if (col_reg == LAST_COL)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/swcr_datapath.sv
`timescale 1ns / 1ps

module swcr_datapath
    import swcr_pkg::*;
#(
    parameter int COLUMNS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swcr_cmd_t            cmd,
    output swcr_status_t         status,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,
    output logic                 m_tlast
);

    localparam int AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int NST = 2 + DIV_ST;

    logic [SAMPLE_W-1:0]        hist_mem [COLUMNS];
    logic [COLUMNS-1:0]         hv_reg;
    logic [SAMPLE_W-1:0]        rd_data_reg;
    logic                       rd_hit_reg;

    logic signed [SAMPLE_W-1:0] min_reg, max_reg;

    logic [NST-1:0]             vld_reg;
    logic [NST-1:0]             last_reg;
    logic [COL_W-1:0]           col_reg [NST];

    logic signed [SAMPLE_W-1:0] clamp_reg, clamp_next;
    logic [SAMPLE_W-1:0]        den1_reg, den1_next;
    logic                       zero1_reg, zero1_next;

    logic [NUM_W-1:0]           rem_reg  [DIV_ST];
    logic [NUM_W-1:0]           rem_next [DIV_ST];
    logic [SAMPLE_W-1:0]        den_reg  [DIV_ST];
    logic [SAMPLE_W-1:0]        den_next [DIV_ST];
    logic [QUO_W-1:0]           quo_reg  [DIV_ST];
    logic [QUO_W-1:0]           quo_next [DIV_ST];
    logic [NUM_W-1:0]           shd      [DIV_ST];
    logic [DIV_ST-1:0]          ge;

    logic signed [SAMPLE_W-1:0] s0;
    logic                       empty;
    logic signed [SAMPLE_W:0]   span;
    logic signed [SAMPLE_W:0]   off;
    logic [NUM_W-1:0]           off_w;
    logic [QUO_W-1:0]           step;
    logic [BYTE_W-1:0]          up_next, lo_next;

    logic                       m_valid_reg;
    logic [COL_W-1:0]           m_col_reg;
    logic [BYTE_W-1:0]          m_up_reg, m_lo_reg;
    logic                       m_last_reg;
    logic                       advance;

    assign advance        = !m_valid_reg || m_tready;
    assign status.advance = advance;

    // history store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            hist_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
        if (advance)
        begin
            rd_data_reg <= hist_mem[cmd.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg     <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                hv_reg[cmd.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (advance)
            begin
                rd_hit_reg <= hv_reg[cmd.rd_addr[AW-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_INPUT_RST;
            max_reg <= MAX_INPUT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MIN_INPUT)
            begin
                min_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MAX_INPUT)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // clamp and span
    always_comb
    begin
        s0    = rd_hit_reg ? signed'(rd_data_reg) : '0;
        empty = (max_reg <= min_reg);
        span  = {max_reg[SAMPLE_W-1], max_reg} - {min_reg[SAMPLE_W-1], min_reg};
        if (s0 < min_reg)
        begin
            clamp_next = min_reg;
        end
        else if (s0 > max_reg)
        begin
            clamp_next = max_reg;
        end
        else
        begin
            clamp_next = s0;
        end
        den1_next  = empty ? SAMPLE_W'(1) : span[SAMPLE_W-1:0];
        zero1_next = empty;
    end

    // scale by fourteen, then restoring division one quotient bit a stage
    always_comb
    begin
        off         = {clamp_reg[SAMPLE_W-1], clamp_reg} - {min_reg[SAMPLE_W-1], min_reg};
        off_w       = NUM_W'(off[SAMPLE_W-1:0]);
        rem_next[0] = zero1_reg ? '0 : (off_w << 4) - (off_w << 1);
        den_next[0] = den1_reg;
        quo_next[0] = '0;
        for (int k = 0; k < DIV_ST; k++)
        begin
            shd[k] = NUM_W'(den_reg[k]) << (DIV_ST - 1 - k);
            ge[k]  = (rem_reg[k] >= shd[k]);
        end
        for (int k = 0; k < DIV_ST - 1; k++)
        begin
            rem_next[k+1] = ge[k] ? rem_reg[k] - shd[k] : rem_reg[k];
            den_next[k+1] = den_reg[k];
            quo_next[k+1] = {quo_reg[k][QUO_W-2:0], ge[k]};
        end
        step = {quo_reg[DIV_ST-1][QUO_W-2:0], ge[DIV_ST-1]};
        up_next = '0;
        lo_next = '0;
        if (step < HALF_STEPS)
        begin
            lo_next = pixel_byte(step[2:0]);
        end
        else
        begin
            up_next = pixel_byte(3'(step - HALF_STEPS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_reg[0]  <= cmd.col;
            for (int s = 1; s < NST; s++)
            begin
                col_reg[s] <= col_reg[s-1];
            end
            clamp_reg <= clamp_next;
            den1_reg  <= den1_next;
            zero1_reg <= zero1_next;
            for (int k = 0; k < DIV_ST; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
            end
            m_col_reg <= col_reg[NST-1];
            m_up_reg  <= up_next;
            m_lo_reg  <= lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= {vld_reg[NST-2:0], cmd.rd_en};
            last_reg    <= {last_reg[NST-2:0], cmd.last};
            m_valid_reg <= vld_reg[NST-1];
            m_last_reg  <= last_reg[NST-1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - COL_W - 2 * BYTE_W){1'b0}}, m_lo_reg, m_up_reg, m_col_reg};
    assign m_tlast  = m_last_reg;

endmodule

### rtl/scrolling_waveform_column_renderer.sv
`timescale 1ns / 1ps
// Throughput: a new sample item is taken only once every column of the last one has been read,
// then one column item per cycle while the output does not stall, set by the single read port
// of the history store.
// Reset (rst_n, asynchronous, active low): history reads as zero, newest slot 0,
// min_input 0, max_input 4095, no items in flight.
module scrolling_waveform_column_renderer
    import swcr_pkg::*;
#(
    parameter int COLUMNS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // [5:0] column, [13:6] upper_page_byte,
                                            // [21:14] lower_page_byte, [23:22] zero
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    swcr_cmd_t    cmd;
    swcr_status_t status;

    assign cfg_ready = 1'b1;

    swcr_ctrl #(
        .COLUMNS (COLUMNS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    swcr_datapath #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/swcr_checker.sv
`timescale 1ns / 1ps

module swcr_props
    import swcr_pkg::*;
#(
    parameter int COLUMNS = 64
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[COL_W-1:0] == LAST_COL)))
        else $error("tlast does not match final column");

    a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            !m_tvalid || (m_tdata[COL_W-1:0] == COL_W'($past(m_tdata[COL_W-1:0]) + 1'b1)))
        else $error("column order broken");

    a_one_page: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:6] == '0) != (m_tdata[21:14] == '0))
        else $error("exactly one page must be lit");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample item taken during redraw");

endmodule

bind scrolling_waveform_column_renderer swcr_props #(
    .COLUMNS (COLUMNS)
) u_swcr_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

### dv/swcr_checker.sv
`timescale 1ns / 1ps

module swcr_checker
    import swcr_pkg::*;
#(
    parameter int COLUMNS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   column_count
);

    // laid out so that {m_tlast, m_tdata} maps onto it directly
    typedef struct packed {
        logic              last;
        logic [1:0]        pad;
        logic [BYTE_W-1:0] lower;
        logic [BYTE_W-1:0] upper;
        logic [COL_W-1:0]  col;
    } column_item_t;

    localparam logic [BYTE_W-1:0] PIXEL [8] = '{
        8'h40, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h01, 8'h20
    };

    logic [SAMPLE_W-1:0] lo_bound;
    logic [SAMPLE_W-1:0] hi_bound;
    logic [SAMPLE_W-1:0] history [COLUMNS];
    int unsigned         newest;
    int unsigned         c;
    column_item_t        expected_columns [$];
    column_item_t        want;
    column_item_t        got;

    function automatic column_item_t draw_column(input logic [SAMPLE_W-1:0] s,
                                                 input logic [SAMPLE_W-1:0] lo,
                                                 input logic [SAMPLE_W-1:0] hi,
                                                 input int unsigned col);
        column_item_t item;
        int           sv;
        int           l;
        int           h;
        int unsigned  level;
        sv = $signed(s);
        l = $signed(lo);
        h = $signed(hi);
        level = 0;
        if (h > l)
        begin
            if (sv < l)
                sv = l;
            if (sv > h)
                sv = h;
            level = (int'(unsigned'(sv - l)) * 14) / (h - l);
        end
        item = '0;
        item.col = COL_W'(col);
        item.last = (col == COLUMNS - 1);
        if (level < HALF_STEPS)
            item.lower = PIXEL[level];
        else
            item.upper = PIXEL[level - HALF_STEPS];
        return item;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_bound = MIN_INPUT_RST;
            hi_bound = MAX_INPUT_RST;
            for (c = 0; c < COLUMNS; c++)
                history[c] = '0;
            newest = 0;
            expected_columns.delete();
            fail_count = 0;
            column_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIN_INPUT)
                    lo_bound = cfg_data;
                else if (cfg_index == CFG_MAX_INPUT)
                    hi_bound = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                newest = (newest + COLUMNS - 1) % COLUMNS;
                history[newest] = s_tdata;
                for (c = 0; c < COLUMNS; c++)
                    expected_columns.push_back(
                        draw_column(history[(newest + c) % COLUMNS], lo_bound, hi_bound, c));
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tlast, m_tdata};
                column_count++;
                if (expected_columns.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected column item, expected none, actual col %0d upper %h lower %h last %b pad %h",
                             $time, got.col, got.upper, got.lower, got.last, got.pad);
                end
                else
                begin
                    want = expected_columns.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: column item mismatch, expected col %0d upper %h lower %h last %b pad %h",
                                 $time, want.col, want.upper, want.lower, want.last, want.pad);
                        $display("%0t:                        actual col %0d upper %h lower %h last %b pad %h",
                                 $time, got.col, got.upper, got.lower, got.last, got.pad);
                    end
                end
            end
        end
        pending = expected_columns.size();
    end

endmodule

### dv/tb_scrolling_waveform_column_renderer.sv
`timescale 1ns / 1ps

module tb_scrolling_waveform_column_renderer;
    import swcr_pkg::*;

    localparam int COLUMNS       = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_GAP       = 13;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 25;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int column_count;
    int sample_count;
    int range_count;
    bit send_burst;
    bit recv_burst;
    bit long_hold_req;

    scrolling_waveform_column_renderer #(
        .COLUMNS (COLUMNS)
    ) u_top (.*);

    swcr_checker #(
        .COLUMNS (COLUMNS)
    ) u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random hold-off per item, one long hold on request
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                gap = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (recv_burst)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_range(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
        write_reg(CFG_MIN_INPUT, lo);
        write_reg(CFG_MAX_INPUT, hi);
        cfg_valid <= 1'b0;
        range_count++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        sample_count++;
    endtask

    // drop valid, wait for every column item, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] lo,
                                                        input logic [SAMPLE_W-1:0] hi);
        int l;
        int h;
        int span;
        int k;
        int v;
        l = $signed(lo);
        h = $signed(hi);
        span = h - l;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = l;
            2: v = h;
            3: v = $urandom_range(0, 1) ? l - 1 : h + 1;
            4:
            begin
                // land on or just below a level boundary
                k = $urandom_range(0, 14);
                v = (span > 0) ? l + (k * span + 13) / 14 - int'($urandom_range(0, 1)) : $urandom;
            end
            default: v = (span > 0) ? l + int'($urandom_range(0, span)) : $urandom;
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic pick_range(output logic [SAMPLE_W-1:0] lo, output logic [SAMPLE_W-1:0] hi);
        int l;
        int h;
        int t;
        l = int'($urandom_range(0, 65535)) - 32768;
        h = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 4))
            0:
            begin
                l = -32768;
                h = 32767;
            end
            1:
            begin
                l = int'($urandom_range(0, 65000)) - 32768;
                h = l + int'($urandom_range(1, 40));
            end
            2: ;
            3: h = l;
            default:
            begin
                if (l > h)
                begin
                    t = l;
                    l = h;
                    h = t;
                end
            end
        endcase
        lo = SAMPLE_W'(l);
        hi = SAMPLE_W'(h);
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset range, history still empty
        send_sample(16'sd0);
        send_sample(16'sd4095);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'sd2047);
        send_sample(16'sd4096);
        send_sample(16'hffff);
        send_sample(16'sd2340);
        wait_drained();

        // full scale; writes to unused indexes must leave the range alone
        write_reg(CFG_MIN_INPUT, 16'h8000);
        write_reg(CFG_MAX_INPUT, 16'h7fff);
        write_reg(CFG_IDX_W'(15), 16'h0000);
        write_reg(CFG_IDX_W'(2), 16'hffff);
        cfg_valid <= 1'b0;
        range_count++;
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        wait_drained();

        // empty range, equal bounds
        set_range(16'sd100, 16'sd100);
        send_sample(16'sd100);
        send_sample(16'sd99);
        send_sample(16'sd101);
        wait_drained();

        // empty range, inverted bounds
        set_range(16'h7fff, 16'h8000);
        send_sample(16'h0000);
        send_sample(16'h7fff);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick_range(lo, hi);
            set_range(lo, hi);
            send_burst = (p == 3) || (p == 6);
            recv_burst = (p == 3);
            if (p == 6)
                long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_sample(pick_sample(lo, hi));
            wait_drained();
        end
        send_burst = 1'b0;
        recv_burst = 1'b0;

        $display("run covered %0d samples over %0d range settings, %0d column items checked",
                 sample_count, range_count, column_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/swcr_pkg.sv
rtl/swcr_ctrl.sv
rtl/swcr_datapath.sv
rtl/scrolling_waveform_column_renderer.sv
rtl/swcr_checker.sv
dv/swcr_checker.sv
dv/tb_scrolling_waveform_column_renderer.sv
